// ===== sv/plhl_pkg.sv =====
// Shared constants and types for the piecewise-linear height lookup block.
package plhl_pkg;

    localparam int MAX_POINTS_DEF = 64;

    localparam int CFG_W  = 7;
    localparam int IDX_W  = 6;
    localparam int X_W    = 16;
    localparam int Y_W    = 16;
    localparam int PROD_W = X_W + Y_W;

    localparam logic [CFG_W-1:0] POINT_COUNT_RST = CFG_W'(2);

    // Request to the divider: a start pulse and the operands.
    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] dividend;
        logic [X_W-1:0]    divisor;
    } t_div_req;

    // Response from the divider: a done pulse and the quotient.
    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] quotient;
    } t_div_rsp;

endpackage

// ===== sv/plhl_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module plhl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/plhl_div.sv =====
// Restoring unsigned divider that produces one quotient bit per cycle.
module plhl_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  plhl_pkg::t_div_req i_req,
    output plhl_pkg::t_div_rsp o_rsp
);

    localparam int DVD_W = plhl_pkg::PROD_W;
    localparam int DSR_W = plhl_pkg::X_W;
    localparam int CNT_W = $clog2(DVD_W);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [DSR_W:0]   r_rem, n_rem;
    logic [DVD_W-1:0] r_quo, n_quo;
    logic [DSR_W-1:0] r_dsr, n_dsr;

    logic [DSR_W:0]   rem_sh;
    logic [DSR_W+1:0] diff;
    logic             fits;

    // The remainder stays below the divisor, so its low bits hold it fully.
    assign rem_sh = {r_rem[DSR_W-1:0], r_quo[DVD_W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, r_dsr};
    assign fits   = !diff[DSR_W+1];

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dsr  = r_dsr;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_req.dividend;
            n_dsr  = i_req.divisor;
        end else if (r_busy) begin
            n_rem = fits ? diff[DSR_W:0] : rem_sh;
            n_quo = {r_quo[DVD_W-2:0], fits};
            n_cnt = r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(DVD_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dsr <= n_dsr;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// ===== sv/piecewise_linear_height_lookup_core.sv =====
// Top level of the piecewise-linear height lookup over a breakpoint table.
// Write items are taken back to back; a query holds the input until its result is registered.
// A query past the last breakpoint skips the scan, a zero-width or reversed segment skips the
// division, and any other takes a scan of one entry per cycle, then a 32-step division.
// Synchronous active-low reset sets point_count to 2 and idles; the table is not cleared.
module piecewise_linear_height_lookup_core #(
    parameter int MAX_POINTS = plhl_pkg::MAX_POINTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input item stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: point_index[5:0], point_x[21:6], point_y[37:22], query_x[53:38], zero pad.
    input  logic [55:0] s_axis_tdata,
    // tuser: mode (0 writes a breakpoint, 1 queries).
    input  logic [0:0]  s_axis_tuser,
    // Result item stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: height[15:0].
    output logic [15:0] m_axis_tdata,
    // tuser: outside.
    output logic [0:0]  m_axis_tuser,
    // Configuration port; point_count lives at byte address 0.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW     = $clog2(MAX_POINTS);
    localparam int CW     = $clog2(MAX_POINTS + 1);
    localparam int CMP_W  = (CW > plhl_pkg::CFG_W) ? CW : plhl_pkg::CFG_W;
    localparam int IW     = (CW > plhl_pkg::IDX_W) ? CW : plhl_pkg::IDX_W;
    localparam int X_W    = plhl_pkg::X_W;
    localparam int Y_W    = plhl_pkg::Y_W;
    localparam int PROD_W = plhl_pkg::PROD_W;

    // Sequencer states.
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_LAST = 4'd1;
    localparam logic [3:0] S_SRCH = 4'd2;
    localparam logic [3:0] S_LEFT = 4'd3;
    localparam logic [3:0] S_MUL  = 4'd4;
    localparam logic [3:0] S_DGO  = 4'd5;
    localparam logic [3:0] S_DIV  = 4'd6;
    localparam logic [3:0] S_SAT  = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    // Item fields.
    logic                        in_mode;
    logic [plhl_pkg::IDX_W-1:0]  in_index;
    logic [X_W-1:0]              in_px;
    logic [Y_W-1:0]              in_py;
    logic [X_W-1:0]              in_qx;

    assign in_mode  = s_axis_tuser[0];
    assign in_index = s_axis_tdata[5:0];
    assign in_px    = s_axis_tdata[21:6];
    assign in_py    = s_axis_tdata[37:22];
    assign in_qx    = s_axis_tdata[53:38];

    // Configuration register.
    logic [plhl_pkg::CFG_W-1:0] r_point_count;
    logic                       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && !paddr[2];
    assign prdata = paddr[2] ? 32'd0 : 32'(r_point_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= plhl_pkg::POINT_COUNT_RST;
        end else if (cfg_wr) begin
            r_point_count <= pwdata[plhl_pkg::CFG_W-1:0];
        end
    end

    // The effective count is clamped to 2..MAX_POINTS; the last valid entry
    // is one below it.
    logic [CMP_W-1:0] cnt_ext;
    logic [CMP_W-1:0] cnt_clamped;
    logic [AW-1:0]    last_idx;

    assign cnt_ext = CMP_W'(r_point_count);

    always_comb begin
        if (cnt_ext < CMP_W'(2)) begin
            cnt_clamped = CMP_W'(2);
        end else if (cnt_ext > CMP_W'(MAX_POINTS)) begin
            cnt_clamped = CMP_W'(MAX_POINTS);
        end else begin
            cnt_clamped = cnt_ext;
        end
    end

    assign last_idx = AW'(cnt_clamped - CMP_W'(1));

    // Breakpoint table: y in the upper half of each word, x in the lower half.
    logic                 in_acc;
    logic                 tbl_we;
    logic [AW-1:0]        rd_addr;
    logic [X_W+Y_W-1:0]   rd_data;
    logic [X_W-1:0]       rd_x;
    logic [Y_W-1:0]       rd_y;

    assign in_acc = s_axis_tvalid && s_axis_tready;
    // A write beyond the table depth is dropped.
    assign tbl_we = in_acc && !in_mode && (IW'(in_index) < IW'(MAX_POINTS));
    assign rd_x   = rd_data[X_W-1:0];
    assign rd_y   = rd_data[X_W+Y_W-1:X_W];

    plhl_ram #(
        .WIDTH (X_W + Y_W),
        .DEPTH (MAX_POINTS)
    ) u_tbl (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (AW'(in_index)),
        .i_wdata ({in_py, in_px}),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // Divider used by the sequencer.
    plhl_pkg::t_div_req div_req;
    plhl_pkg::t_div_rsp div_rsp;

    plhl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Sequencer registers.
    logic [3:0]        r_state, n_state;
    logic [X_W-1:0]    r_q, n_q;
    logic [AW-1:0]     r_last, n_last;
    logic [AW-1:0]     r_ptr, n_ptr;
    logic [AW-1:0]     r_didx, n_didx;
    logic              r_dv, n_dv;
    logic [X_W-1:0]    r_xr, n_xr;
    logic [Y_W-1:0]    r_yr, n_yr;
    logic [X_W-1:0]    r_xl, n_xl;
    logic [Y_W-1:0]    r_yl, n_yl;
    logic [PROD_W-1:0] r_prod, n_prod;
    logic              r_neg, n_neg;
    logic [X_W-1:0]    r_w, n_w;
    logic [Y_W-1:0]    r_res_h, n_res_h;
    logic              r_res_o, n_res_o;

    // Output register.
    logic           r_out_valid;
    logic [Y_W-1:0] r_out_height;
    logic           r_out_outside;
    logic           out_load;

    // Segment arithmetic, all on 17-bit two's complement differences.
    logic [X_W:0]   w_diff;
    logic [X_W:0]   dx_diff;
    logic [Y_W:0]   dy_diff;
    logic [X_W:0]   dx_abs;
    logic [Y_W:0]   dy_abs;
    logic           w_nonpos;

    assign w_diff   = {1'b0, r_xr} - {1'b0, r_xl};
    assign dx_diff  = {1'b0, r_q} - {1'b0, r_xl};
    assign dy_diff  = {1'b0, r_yr} - {1'b0, r_yl};
    assign dx_abs   = dx_diff[X_W] ? (~dx_diff + (X_W+1)'(1)) : dx_diff;
    assign dy_abs   = dy_diff[Y_W] ? (~dy_diff + (Y_W+1)'(1)) : dy_diff;
    assign w_nonpos = w_diff[X_W] || (w_diff == '0);

    // Saturating add of the signed quotient to the left height.
    logic [PROD_W:0] pos_sum;

    assign pos_sum = {1'b0, div_rsp.quotient} + (PROD_W+1)'(r_yl);

    assign div_req.start    = (r_state == S_DGO);
    assign div_req.dividend = r_prod;
    assign div_req.divisor  = r_w;

    assign s_axis_tready = (r_state == S_IDLE);
    assign out_load      = (r_state == S_OUT) && (!r_out_valid || m_axis_tready);

    always_comb begin
        n_state = r_state;
        n_q     = r_q;
        n_last  = r_last;
        n_ptr   = r_ptr;
        n_didx  = r_didx;
        n_dv    = r_dv;
        n_xr    = r_xr;
        n_yr    = r_yr;
        n_xl    = r_xl;
        n_yl    = r_yl;
        n_prod  = r_prod;
        n_neg   = r_neg;
        n_w     = r_w;
        n_res_h = r_res_h;
        n_res_o = r_res_o;
        rd_addr = '0;
        case (r_state)
            S_IDLE: begin
                // A query first fetches the last valid breakpoint.
                rd_addr = last_idx;
                if (in_acc && in_mode) begin
                    n_q     = in_qx;
                    n_last  = last_idx;
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                if (r_q > rd_x) begin
                    n_res_h = '0;
                    n_res_o = 1'b1;
                    n_state = S_OUT;
                end else begin
                    n_ptr   = AW'(1);
                    n_dv    = 1'b0;
                    n_state = S_SRCH;
                end
            end
            S_SRCH: begin
                // Reads are issued one entry per cycle; each compare sees the
                // entry issued in the cycle before. The scan stops at the first
                // right x above the query, or at the last entry.
                rd_addr = r_ptr;
                n_didx  = r_ptr;
                n_dv    = 1'b1;
                if (r_ptr != r_last) begin
                    n_ptr = r_ptr + AW'(1);
                end
                if (r_dv && ((rd_x > r_q) || (r_didx == r_last))) begin
                    n_xr    = rd_x;
                    n_yr    = rd_y;
                    rd_addr = r_didx - AW'(1);
                    n_state = S_LEFT;
                end
            end
            S_LEFT: begin
                n_xl    = rd_x;
                n_yl    = rd_y;
                n_state = S_MUL;
            end
            S_MUL: begin
                // A zero-width or reversed segment answers its left height.
                if (w_nonpos) begin
                    n_res_h = r_yl;
                    n_res_o = 1'b0;
                    n_state = S_OUT;
                end else begin
                    n_prod  = dx_abs[X_W-1:0] * dy_abs[Y_W-1:0];
                    n_neg   = dx_diff[X_W] ^ dy_diff[Y_W];
                    n_w     = w_diff[X_W-1:0];
                    n_state = S_DGO;
                end
            end
            S_DGO: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    n_state = S_SAT;
                end
            end
            S_SAT: begin
                n_res_o = 1'b0;
                if (r_neg) begin
                    if (div_rsp.quotient > PROD_W'(r_yl)) begin
                        n_res_h = '0;
                    end else begin
                        n_res_h = r_yl - div_rsp.quotient[Y_W-1:0];
                    end
                end else begin
                    if (pos_sum > (PROD_W+1)'({Y_W{1'b1}})) begin
                        n_res_h = '1;
                    end else begin
                        n_res_h = pos_sum[Y_W-1:0];
                    end
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dv    <= n_dv;
        end
        r_q     <= n_q;
        r_last  <= n_last;
        r_ptr   <= n_ptr;
        r_didx  <= n_didx;
        r_xr    <= n_xr;
        r_yr    <= n_yr;
        r_xl    <= n_xl;
        r_yl    <= n_yl;
        r_prod  <= n_prod;
        r_neg   <= n_neg;
        r_w     <= n_w;
        r_res_h <= n_res_h;
        r_res_o <= n_res_o;
    end

    // The result register lets a finished item wait while the sequencer
    // already goes back to taking write items.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (out_load) begin
            r_out_height  <= r_res_h;
            r_out_outside <= r_res_o;
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out_height;
    assign m_axis_tuser[0] = r_out_outside;

endmodule

// ===== sv/plhl_chk.sv =====
// Port-level checker for the height lookup block, with its bind statement.
module plhl_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [55:0] s_axis_tdata,
    input logic [0:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // An outside answer always carries zero height.
    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 16'd0)
        else $error("outside result with nonzero height");

    // A query keeps the block busy for at least the next cycle.
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser[0] |=> !s_axis_tready)
        else $error("ready right after a query");

    // A write item taken with no result pending gives no result.
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && !s_axis_tuser[0] && !m_axis_tvalid
            |=> !m_axis_tvalid)
        else $error("write item produced a result");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind piecewise_linear_height_lookup_core plhl_chk u_plhl_chk (.*);
